// ===== rtl/core/trial_division_prime_test_macros.svh =====
// assertion helpers for the trial division prime test
`ifndef TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define TDPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define TDPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tdpt_pkg.sv =====
`default_nettype none

package tdpt_pkg;

  // width of the number under test
  localparam int unsigned NumWidth = 16;
  // bit counter for one serial division pass
  localparam int unsigned CntWidth = (NumWidth > 1) ? $clog2(NumWidth) : 1;
  localparam logic [CntWidth-1:0] CntLast = CntWidth'(NumWidth - 1);

  typedef logic [NumWidth-1:0] num_t;

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StDiv,
    StCheck,
    StFinish
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/tdpt_if.sv =====
`default_nettype none

// candidate channel
interface tdpt_cand_if;
  logic                 valid;
  logic                 ready;
  tdpt_pkg::num_t       candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

// result channel
interface tdpt_res_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/trial_division_prime_test.sv =====
// channel   dir  handshake       payload
// cand_i    in   valid / ready   candidate [NumWidth-1:0] unsigned
// res_o     out  valid / ready   is_prime  [0]
//
// each divisor d = 2, 3, ... costs one restoring division, one bit per cycle,
// followed by the check state; a prime v runs one division for each d from 2
// up to floor(sqrt(v)) + 1; zero and one skip the divisions and go straight
// to the result, reported as not prime.
// one item is in flight at a time; the result register lets the next item start
// while the previous result is stalled on res_o.ready.
// reset clears the control state only; no clearing pass.
`default_nettype none

`include "trial_division_prime_test_macros.svh"

module trial_division_prime_test (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  tdpt_cand_if.sink    cand_i,
  tdpt_res_if.source   res_o
);
  import tdpt_pkg::*;

  state_e               state_q, state_d;
  num_t                 val_q, val_d;     // value under test
  num_t                 div_q, div_d;     // current divisor
  num_t                 work_q, work_d;   // dividend bits out, quotient bits in
  num_t                 rem_q, rem_d;     // partial remainder
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic                 prime_q, prime_d; // primality verdict waiting for the output
  logic                 out_valid_q, out_valid_d;
  logic                 out_prime_q, out_prime_d;

  logic [NumWidth:0]    trial;
  logic                 fits;

  // one restoring division step
  assign trial = {rem_q, work_q[NumWidth-1]};
  assign fits  = (trial >= {1'b0, div_q});

  // control and datapath
  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    div_d       = div_q;
    work_d      = work_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    prime_d     = prime_q;
    out_valid_d = out_valid_q;
    out_prime_d = out_prime_q;

    // result register drains on a beat
    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (cand_i.valid) begin
          val_d   = cand_i.candidate;
          state_d = StLoad;
        end
      end
      StLoad: begin
        div_d  = NumWidth'(2);
        work_d = val_q;
        rem_d  = '0;
        cnt_d  = CntLast;
        if (val_q < NumWidth'(2)) begin
          prime_d = 1'b0;
          state_d = StFinish;
        end else begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (fits) begin
          rem_d = NumWidth'(trial - {1'b0, div_q});
        end else begin
          rem_d = trial[NumWidth-1:0];
        end
        work_d = {work_q[NumWidth-2:0], fits};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        // quotient below divisor means divisor squared exceeds the value
        if (work_q < div_q) begin
          prime_d = 1'b1;
          state_d = StFinish;
        end else if (rem_q == '0) begin
          prime_d = 1'b0;
          state_d = StFinish;
        end else begin
          div_d   = div_q + 1'b1;
          work_d  = val_q;
          rem_d   = '0;
          cnt_d   = CntLast;
          state_d = StDiv;
        end
      end
      StFinish: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_prime_d = prime_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    div_q       <= div_d;
    work_q      <= work_d;
    rem_q       <= rem_d;
    cnt_q       <= cnt_d;
    prime_q     <= prime_d;
    out_prime_q <= out_prime_d;
  end

  assign cand_i.ready   = (state_q == StIdle);
  assign res_o.valid    = out_valid_q;
  assign res_o.is_prime = out_prime_q;

  // checks
  `TDPT_ASSERT_NOW(a_div_min, state_q == StDiv, div_q >= NumWidth'(2),
                   "divisor below two during division")
  `TDPT_ASSERT_NOW(a_rem_bound, state_q == StDiv || state_q == StCheck, rem_q < div_q,
                   "partial remainder not below divisor")
  `TDPT_ASSERT_NEXT(a_accept_load, cand_i.valid && cand_i.ready, state_q == StLoad,
                    "accepted beat did not start a test")
  `TDPT_ASSERT_NEXT(a_out_drain, res_o.valid && res_o.ready && state_q != StFinish,
                    !res_o.valid, "result beat repeated")

endmodule

`default_nettype wire
